// ===== hw/rtl/mpi_pkg.sv =====
// shared constants, types and helpers for the escape-time pixel iterator
`default_nettype none
package mpi_pkg;

	// number formats
	localparam int FRAC_BITS     = 60;
	localparam int LOG_FRAC_BITS = 16;
	localparam int ITER_BITS     = 32;
	localparam int NUM_W         = 64;
	localparam int PROD_W        = 2 * NUM_W;

	// colouring constants
	localparam int HUE_SCALE = 576;
	localparam int HUE_W     = 16;

	// register indexes
	localparam logic [2:0] REG_MAX_ITER   = 3'd0;
	localparam logic [2:0] REG_PRIOR_ITER = 3'd1;
	localparam logic [2:0] REG_JULIA_MODE = 3'd2;
	localparam logic [2:0] REG_SEED_REAL  = 3'd3;
	localparam logic [2:0] REG_SEED_IMAG  = 3'd4;

	// operation codes
	localparam logic OP_CHECK   = 1'b0;
	localparam logic OP_ITERATE = 1'b1;

	// outcome codes
	localparam logic [1:0] OUT_UNRESOLVED = 2'd0;
	localparam logic [1:0] OUT_CAPTURED   = 2'd1;
	localparam logic [1:0] OUT_ESCAPED    = 2'd2;
	localparam logic [1:0] OUT_UNTOUCHED  = 2'd3;

	// request to the shared multiplier
	typedef struct packed {
		logic                    start;
		logic signed [NUM_W-1:0] a;
		logic signed [NUM_W-1:0] b;
	} mul_req_t;

	// result from the shared multiplier
	typedef struct packed {
		logic                     done;
		logic signed [PROD_W-1:0] p;
	} mul_rsp_t;

	// saturate a wide signed value to the number width
	function automatic logic [NUM_W-1:0] sat_num(input logic [PROD_W-1:0] v);
		logic [NUM_W-1:0] r;
		if (v[PROD_W-1:NUM_W-1] == '0 || v[PROD_W-1:NUM_W-1] == '1) begin
			r = v[NUM_W-1:0];
		end else if (v[PROD_W-1]) begin
			r = {1'b1, {(NUM_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(NUM_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mpi_mul.sv =====
// shared signed 64x64 multiplier built from four 32x32 partial products
`default_nettype none
module mpi_mul (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mpi_pkg::mul_req_t req,
	output mpi_pkg::mul_rsp_t      rsp
);

	localparam int HALF_W = mpi_pkg::NUM_W / 2;

	logic                            busy_q;
	logic [2:0]                      step_q;
	logic                            neg_q;
	logic [mpi_pkg::NUM_W-1:0]       ua_q;
	logic [mpi_pkg::NUM_W-1:0]       ub_q;
	logic [mpi_pkg::NUM_W-1:0]       pp_q;
	logic [1:0]                      psh_q;
	logic [mpi_pkg::PROD_W-1:0]      acc_q;
	logic [mpi_pkg::PROD_W-1:0]      res_q;
	logic                            done_q;

	logic [HALF_W-1:0]               ah;
	logic [HALF_W-1:0]               bh;
	logic [mpi_pkg::PROD_W-1:0]      pp_ext;
	logic [mpi_pkg::PROD_W-1:0]      pp_sh;

	// pick the halves for this step
	always_comb begin
		ah     = step_q[1] ? ua_q[mpi_pkg::NUM_W-1:HALF_W] : ua_q[HALF_W-1:0];
		bh     = step_q[0] ? ub_q[mpi_pkg::NUM_W-1:HALF_W] : ub_q[HALF_W-1:0];
		pp_ext = {{mpi_pkg::NUM_W{1'b0}}, pp_q};
		case (psh_q)
			2'd0:    pp_sh = pp_ext;
			2'd1:    pp_sh = pp_ext << HALF_W;
			default: pp_sh = pp_ext << mpi_pkg::NUM_W;
		endcase
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 3'd1;
			end
		end
	end

	// magnitudes, partial products and accumulation
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			ua_q  <= req.a[mpi_pkg::NUM_W-1] ? (~req.a + 1'b1) : req.a;
			ub_q  <= req.b[mpi_pkg::NUM_W-1] ? (~req.b + 1'b1) : req.b;
			neg_q <= req.a[mpi_pkg::NUM_W-1] ^ req.b[mpi_pkg::NUM_W-1];
			acc_q <= '0;
		end else if (busy_q) begin
			if (step_q < 3'd4) begin
				pp_q  <= ah * bh;
				psh_q <= {1'b0, step_q[1]} + {1'b0, step_q[0]};
			end
			if (step_q >= 3'd1 && step_q <= 3'd4) begin
				acc_q <= acc_q + pp_sh;
			end
			if (step_q == 3'd5) begin
				res_q <= neg_q ? (~acc_q + 1'b1) : acc_q;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = res_q;

endmodule
`default_nettype wire

// ===== hw/rtl/mandelbrot_pixel_iterator.sv =====
// escape-time pixel iterator with cardioid check and smooth log2 colouring
//
// channel   direction  payload
// s_axis    in         tdata: point, orbit, slow orbit; tuser: operation, resolved_in
// m_axis    out        tdata: colour, orbit out, slow out; tuser: outcome, resolved_out
// cfg       in         cfg_we, cfg_addr, cfg_wdata register writes
//
// every product goes through one shared multiplier;
// an escape adds up to three log2 passes.
// the input is taken only in idle; the result waits in an output register,
// and the next item is accepted once it has been moved into it.
// reset returns the registers to their defaults and drops m_axis_tvalid.
`default_nettype none
module mandelbrot_pixel_iterator (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// point_real, point_imag, orbit_real, orbit_imag, slow_real, slow_imag
	input  wire logic [383:0] s_axis_tdata,
	// operation, resolved_in
	input  wire logic [1:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// colour, orbit_real_out, orbit_imag_out, slow_real_out, slow_imag_out
	output logic [279:0]      m_axis_tdata,
	// outcome, resolved_out
	output logic [2:0]        m_axis_tuser,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_addr,
	input  wire logic [63:0]  cfg_wdata
);

	localparam int NW  = mpi_pkg::NUM_W;
	localparam int PW  = mpi_pkg::PROD_W;
	localparam int FB  = mpi_pkg::FRAC_BITS;
	localparam int LFB = mpi_pkg::LOG_FRAC_BITS;
	localparam int IB  = mpi_pkg::ITER_BITS;
	localparam int KW  = $clog2(LFB + 1);
	localparam int SHW = $clog2(PW);

	localparam logic signed [NW-1:0] ONE    = NW'(1) << FB;
	localparam logic signed [NW-1:0] TWO    = NW'(1) << (FB + 1);
	localparam logic signed [NW-1:0] FOUR   = NW'(1) << (FB + 2);
	localparam logic signed [NW-1:0] QUART  = NW'(1) << (FB - 2);
	localparam logic signed [PW-1:0] BULB_R = PW'(1) << (2 * FB - 4);
	localparam logic signed [NW-1:0] LOG_ONE = NW'(1) << LFB;

	typedef enum logic [23:0] {
		ST_IDLE     = 24'h000001,
		ST_BOX      = 24'h000002,
		ST_CK_CI2   = 24'h000004,
		ST_CK_XX    = 24'h000008,
		ST_CK_Q     = 24'h000010,
		ST_CK_LHS   = 24'h000020,
		ST_CK_CMP   = 24'h000040,
		ST_CK_YY    = 24'h000080,
		ST_CK_BULB  = 24'h000100,
		ST_IT_START = 24'h000200,
		ST_IT_RR    = 24'h000400,
		ST_IT_II    = 24'h000800,
		ST_IT_RI    = 24'h001000,
		ST_IT_UPD   = 24'h002000,
		ST_IT_TEST  = 24'h004000,
		ST_ZM_RR    = 24'h008000,
		ST_ZM_II    = 24'h010000,
		ST_LG_NORM  = 24'h020000,
		ST_LG_SQ    = 24'h040000,
		ST_LG_FIN   = 24'h080000,
		ST_CLR      = 24'h100000,
		ST_HUE      = 24'h200000,
		ST_COLOUR   = 24'h400000,
		ST_FIN      = 24'h800000
	} state_t;

	typedef enum logic [1:0] {
		LG_ABS_SQ = 2'd0,
		LG_NU     = 2'd1,
		LG_CLR    = 2'd2
	} lg_sel_t;

	state_t state_q;

	// configuration registers
	logic [IB-1:0]          max_iter_q;
	logic [IB-1:0]          prior_iter_q;
	logic                   julia_mode_q;
	logic signed [NW-1:0]   seed_real_q;
	logic signed [NW-1:0]   seed_imag_q;

	// working registers
	logic signed [NW-1:0]   zr_q, zi_q, sr_q, si_q, cr_q, ci_q, x_q, qf_q;
	logic signed [PW-1:0]   t0_q, t1_q;
	logic                   op_q, slow_q, mul_wait_q;
	logic [IB-1:0]          iter_q, cnt_q;
	logic [1:0]             outcome_q;
	logic [23:0]            colour_q;

	// log2 unit state
	logic [PW-1:0]          lg_m_q;
	logic [SHW-1:0]         lg_sh_q;
	logic [7:0]             lg_pt_q;
	logic                   lg_zero_q;
	logic [31:0]            lg_y_q;
	logic [LFB-1:0]         lg_frac_q;
	logic [KW-1:0]          lg_k_q;
	lg_sel_t                lg_sel_q;
	logic [NW-1:0]          nu_q, lgr_q;
	logic [HUE_W_L-1:0]     hue_q;

	localparam int HUE_W_L = mpi_pkg::HUE_W;

	// output register
	logic                   ovalid_q;
	logic [1:0]             o_outcome_q;
	logic [23:0]            o_colour_q;
	logic [NW-1:0]          o_zr_q, o_zi_q, o_sr_q, o_si_q;

	mpi_pkg::mul_req_t      mreq;
	mpi_pkg::mul_rsp_t      mrsp;

	logic                   mul_state;
	logic signed [NW-1:0]   pr, pi;
	logic signed [PW-1:0]   re_w, im_w, clr_sum;
	logic [NW-1:0]          lg_res, clr_w;
	logic [6:0]             lg_e;
	logic [32:0]            ysq;
	logic [IB+1:0]          cnt_w;
	logic [7:0]             sec_v;
	logic [15:0]            sec_p;
	logic [5:0]             sec_q;
	logic [7:0]             sec_r;
	logic [7:0]             coord;
	logic [23:0]            colour_w;
	logic [NW+9:0]          hue_p;
	logic                   escaped, in_box, ck_lt, bulb_lt;

	// shared multiplier
	mpi_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	// operand selection for the multiplier
	always_comb begin
		pr        = slow_q ? sr_q : zr_q;
		pi        = slow_q ? si_q : zi_q;
		mul_state = 1'b1;
		mreq.a    = '0;
		mreq.b    = '0;
		unique case (state_q)
			ST_CK_CI2: begin mreq.a = ci_q; mreq.b = ci_q; end
			ST_CK_XX:  begin mreq.a = x_q; mreq.b = x_q; end
			ST_CK_LHS: begin mreq.a = qf_q; mreq.b = qf_q + x_q; end
			ST_CK_YY:  begin mreq.a = cr_q + ONE; mreq.b = cr_q + ONE; end
			ST_IT_RR:  begin mreq.a = pr; mreq.b = pr; end
			ST_IT_II:  begin mreq.a = pi; mreq.b = pi; end
			ST_IT_RI:  begin mreq.a = pr; mreq.b = pi; end
			ST_ZM_RR:  begin mreq.a = zr_q; mreq.b = zr_q; end
			ST_ZM_II:  begin mreq.a = zi_q; mreq.b = zi_q; end
			ST_LG_SQ:  begin
				mreq.a = {{(NW-32){1'b0}}, lg_y_q};
				mreq.b = {{(NW-32){1'b0}}, lg_y_q};
			end
			default:   mul_state = 1'b0;
		endcase
		mreq.start = mul_state && !mul_wait_q;
	end

	// datapath helpers
	always_comb begin
		re_w    = (t0_q >>> FB) + PW'(cr_q);
		im_w    = (t1_q >>> (FB - 1)) + PW'(ci_q);
		escaped = (zr_q < -FOUR) || (zr_q > FOUR) || (zi_q < -FOUR) || (zi_q > FOUR);
		in_box  = (cr_q > -TWO) && (cr_q < TWO) && (ci_q > -ONE) && (ci_q < ONE);
		ck_lt   = t0_q < (t1_q >>> 2);
		clr_sum = t0_q + t1_q;
		bulb_lt = clr_sum < BULB_R;
		cnt_w   = {2'b00, iter_q} + {2'b00, prior_iter_q} + (IB+2)'(1);
		ysq     = mrsp.p[63:31];
		lg_e    = 7'(PW - 1) - 7'(lg_sh_q);
		lg_res  = lg_zero_q ? '0 :
			((((NW)'(lg_e) - (NW)'(lg_pt_q)) << LFB) | (NW)'(lg_frac_q));
		clr_w   = ({{(NW-IB){1'b0}}, cnt_q} << LFB) - nu_q;
		hue_p   = lgr_q * (NW+10)'(mpi_pkg::HUE_SCALE);
		sec_v   = hue_q[15:8];
		sec_p   = sec_v * 16'd171;
		sec_q   = sec_p[15:10];
		sec_r   = sec_v - 8'(sec_q * 6'd6);
		coord   = hue_q[7:0];
		case (sec_r)
			8'd0:    colour_w = {8'd0, coord, 8'hFF};
			8'd1:    colour_w = {8'd0, 8'hFF, 8'hFF - coord};
			8'd2:    colour_w = {coord, 8'hFF, 8'd0};
			8'd3:    colour_w = {8'hFF, 8'hFF - coord, 8'd0};
			8'd4:    colour_w = {8'hFF, 8'd0, coord};
			default: colour_w = {8'hFF - coord, 8'd0, 8'hFF};
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q   <= IB'(1000);
			prior_iter_q <= '0;
			julia_mode_q <= 1'b0;
			seed_real_q  <= '0;
			seed_imag_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				mpi_pkg::REG_MAX_ITER:   max_iter_q   <= cfg_wdata[IB-1:0];
				mpi_pkg::REG_PRIOR_ITER: prior_iter_q <= cfg_wdata[IB-1:0];
				mpi_pkg::REG_JULIA_MODE: julia_mode_q <= cfg_wdata[0];
				mpi_pkg::REG_SEED_REAL:  seed_real_q  <= cfg_wdata;
				mpi_pkg::REG_SEED_IMAG:  seed_imag_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mul_wait_q <= 1'b0;
			ovalid_q   <= 1'b0;
		end else begin
			if (ovalid_q && m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
			if (mreq.start) begin
				mul_wait_q <= 1'b1;
			end else if (mrsp.done) begin
				mul_wait_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						if (s_axis_tuser[1]) begin
							state_q <= ST_FIN;
						end else if (s_axis_tuser[0] == mpi_pkg::OP_CHECK) begin
							state_q <= ST_BOX;
						end else begin
							state_q <= ST_IT_START;
						end
					end
				end
				ST_BOX:     state_q <= in_box ? ST_CK_CI2 : ST_FIN;
				ST_CK_CI2:  if (mrsp.done) state_q <= ST_CK_XX;
				ST_CK_XX:   if (mrsp.done) state_q <= ST_CK_Q;
				ST_CK_Q:    state_q <= ST_CK_LHS;
				ST_CK_LHS:  if (mrsp.done) state_q <= ST_CK_CMP;
				ST_CK_CMP:  state_q <= ck_lt ? ST_FIN : ST_CK_YY;
				ST_CK_YY:   if (mrsp.done) state_q <= ST_CK_BULB;
				ST_CK_BULB: state_q <= ST_FIN;
				ST_IT_START: state_q <= (iter_q >= max_iter_q) ? ST_FIN : ST_IT_RR;
				ST_IT_RR:   if (mrsp.done) state_q <= ST_IT_II;
				ST_IT_II:   if (mrsp.done) state_q <= ST_IT_RI;
				ST_IT_RI:   if (mrsp.done) state_q <= ST_IT_UPD;
				ST_IT_UPD:  state_q <= (!slow_q && iter_q[0]) ? ST_IT_RR : ST_IT_TEST;
				ST_IT_TEST: begin
					if (zr_q == sr_q && zi_q == si_q) begin
						state_q <= ST_FIN;
					end else if (escaped) begin
						state_q <= ST_ZM_RR;
					end else begin
						state_q <= ST_IT_START;
					end
				end
				ST_ZM_RR:   if (mrsp.done) state_q <= ST_ZM_II;
				ST_ZM_II:   if (mrsp.done) state_q <= ST_LG_NORM;
				ST_LG_NORM: begin
					if (lg_m_q == '0) begin
						state_q <= ST_LG_FIN;
					end else if (lg_m_q[PW-1]) begin
						state_q <= ST_LG_SQ;
					end
				end
				ST_LG_SQ: begin
					if (mrsp.done && lg_k_q == KW'(LFB - 1)) begin
						state_q <= ST_LG_FIN;
					end
				end
				ST_LG_FIN: begin
					unique case (lg_sel_q)
						LG_ABS_SQ: state_q <= ST_LG_NORM;
						LG_NU:     state_q <= ST_CLR;
						default:   state_q <= ST_HUE;
					endcase
				end
				ST_CLR: begin
					state_q <= ($signed(clr_w) < LOG_ONE) ? ST_COLOUR : ST_LG_NORM;
				end
				ST_HUE:    state_q <= ST_COLOUR;
				ST_COLOUR: state_q <= ST_FIN;
				ST_FIN: begin
					if (!ovalid_q || m_axis_tready) begin
						ovalid_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				op_q      <= s_axis_tuser[0];
				zr_q      <= s_axis_tdata[2*NW +: NW];
				zi_q      <= s_axis_tdata[3*NW +: NW];
				sr_q      <= s_axis_tdata[4*NW +: NW];
				si_q      <= s_axis_tdata[5*NW +: NW];
				iter_q    <= '0;
				slow_q    <= 1'b0;
				colour_q  <= '0;
				outcome_q <= s_axis_tuser[1] ? mpi_pkg::OUT_UNTOUCHED
					: mpi_pkg::OUT_UNRESOLVED;
				if (s_axis_tuser[0] == mpi_pkg::OP_ITERATE && julia_mode_q) begin
					cr_q <= seed_real_q;
					ci_q <= seed_imag_q;
				end else begin
					cr_q <= s_axis_tdata[0 +: NW];
					ci_q <= s_axis_tdata[NW +: NW];
				end
			end
			ST_BOX: x_q <= cr_q - QUART;
			ST_CK_CI2: if (mrsp.done) t1_q <= mrsp.p;
			ST_CK_XX:  if (mrsp.done) t0_q <= mrsp.p + t1_q;
			ST_CK_Q:   qf_q <= mpi_pkg::sat_num(t0_q >>> FB);
			ST_CK_LHS: if (mrsp.done) t0_q <= mrsp.p;
			ST_CK_CMP: if (ck_lt) outcome_q <= mpi_pkg::OUT_CAPTURED;
			ST_CK_YY:  if (mrsp.done) t0_q <= mrsp.p;
			ST_CK_BULB: if (bulb_lt) outcome_q <= mpi_pkg::OUT_CAPTURED;
			ST_IT_START: slow_q <= 1'b0;
			ST_IT_RR:  if (mrsp.done) t0_q <= mrsp.p;
			ST_IT_II:  if (mrsp.done) t1_q <= mrsp.p;
			ST_IT_RI: begin
				if (mrsp.done) begin
					t0_q <= t0_q - t1_q;
					t1_q <= mrsp.p;
				end
			end
			ST_IT_UPD: begin
				if (slow_q) begin
					sr_q <= mpi_pkg::sat_num(re_w);
					si_q <= mpi_pkg::sat_num(im_w);
				end else begin
					zr_q <= mpi_pkg::sat_num(re_w);
					zi_q <= mpi_pkg::sat_num(im_w);
				end
				slow_q <= !slow_q && iter_q[0];
			end
			ST_IT_TEST: begin
				if (zr_q == sr_q && zi_q == si_q) begin
					outcome_q <= mpi_pkg::OUT_CAPTURED;
				end else if (escaped) begin
					outcome_q <= mpi_pkg::OUT_ESCAPED;
					cnt_q     <= (cnt_w[IB+1:IB] != 2'b00) ? '1 : cnt_w[IB-1:0];
				end else begin
					iter_q <= iter_q + IB'(1);
				end
			end
			ST_ZM_RR: if (mrsp.done) t0_q <= mrsp.p;
			ST_ZM_II: begin
				if (mrsp.done) begin
					lg_m_q   <= t0_q + mrsp.p;
					lg_pt_q  <= 8'(2 * FB);
					lg_sel_q <= LG_ABS_SQ;
					lg_sh_q  <= '0;
				end
			end
			ST_LG_NORM: begin
				lg_zero_q <= (lg_m_q == '0);
				lg_k_q    <= '0;
				lg_frac_q <= '0;
				lg_y_q    <= lg_m_q[PW-1 -: 32];
				if (!lg_m_q[PW-1] && lg_m_q != '0) begin
					if (lg_m_q[PW-1 -: 8] == 8'd0) begin
						lg_m_q  <= lg_m_q << 8;
						lg_sh_q <= lg_sh_q + SHW'(8);
					end else begin
						lg_m_q  <= lg_m_q << 1;
						lg_sh_q <= lg_sh_q + SHW'(1);
					end
				end
			end
			ST_LG_SQ: begin
				if (mrsp.done) begin
					lg_k_q    <= lg_k_q + KW'(1);
					lg_frac_q <= {lg_frac_q[LFB-2:0], ysq[32]};
					lg_y_q    <= ysq[32] ? ysq[32:1] : ysq[31:0];
				end
			end
			ST_LG_FIN: begin
				lg_sh_q <= '0;
				unique case (lg_sel_q)
					LG_ABS_SQ: begin
						lg_m_q   <= {{(PW-NW){1'b0}}, lg_res};
						lg_pt_q  <= 8'(LFB);
						lg_sel_q <= LG_NU;
					end
					LG_NU:   nu_q  <= lg_res - LOG_ONE;
					default: lgr_q <= lg_res;
				endcase
			end
			ST_CLR: begin
				hue_q    <= '0;
				lg_m_q   <= {{(PW-NW){1'b0}}, clr_w};
				lg_pt_q  <= 8'(LFB);
				lg_sel_q <= LG_CLR;
				lg_sh_q  <= '0;
			end
			ST_HUE:    hue_q    <= hue_p[LFB +: HUE_W_L];
			ST_COLOUR: colour_q <= colour_w;
			ST_FIN: begin
				if (!ovalid_q || m_axis_tready) begin
					o_outcome_q <= outcome_q;
					o_colour_q  <= colour_q;
					o_zr_q      <= zr_q;
					o_zi_q      <= zi_q;
					o_sr_q      <= sr_q;
					o_si_q      <= si_q;
				end
			end
			default: ;
		endcase
	end

	// ports
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {o_si_q, o_sr_q, o_zi_q, o_zr_q, o_colour_q};
	assign m_axis_tuser  = {(o_outcome_q != mpi_pkg::OUT_UNRESOLVED), o_outcome_q};

	logic unused_op;
	assign unused_op = op_q;

endmodule
`default_nettype wire
